FILE: hdl/line_editor_with_echo_assert.svh
// Assertion macros used by the line editor's result sequencer (lne_seq).
// Files that check their own logic take this header by include.
`ifndef LINE_EDITOR_WITH_ECHO_ASSERT_SVH
`define LINE_EDITOR_WITH_ECHO_ASSERT_SVH

// Checked on every clock edge outside reset.
`define LNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LNE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/lne_pkg.sv
// Package of the line editor: character codes, command kinds and the
// command record handed from the decoder to the result sequencer. No dependencies.
package lne_pkg;

  localparam int unsigned LINE_BUFFER_SIZE = 64;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned LEN_W   = 6;

  localparam logic [CHAR_W-1:0] CH_ESC    = 8'd27;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BS     = 8'd8;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BEL    = 8'd7;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'd92;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'd0;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    KIND_ECHO,
    KIND_KILL,
    KIND_ERASE,
    KIND_BELL,
    KIND_LINE_END,
    KIND_READ
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] ch;
    logic              done;
    logic [LEN_W-1:0]  len;
    logic              rd_zero;
  } cmd_t;

endpackage

FILE: hdl/lne_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the line store. No dependencies.
module lne_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lne_seq.sv
// Result sequencer: holds one decoded command and emits its results, one per
// cycle unless stalled, into the output register. Depends on lne_pkg and the assertion header.
`include "line_editor_with_echo_assert.svh"

module lne_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  lne_pkg::cmd_t                  cmd_i,
  input  logic [lne_pkg::CHAR_W-1:0]     rdata_i,
  output logic                           take_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           tx_valid_o,
  output logic [lne_pkg::CHAR_W-1:0]     tx_byte_o,
  output logic                           line_done_o,
  output logic [lne_pkg::LEN_W-1:0]      line_length_o,
  output logic [lne_pkg::CHAR_W-1:0]     read_data_o,
  output logic                           last_o
);

  logic          gen_valid_q, gen_valid_d;
  lne_pkg::cmd_t cmd_q, cmd_d;
  logic [1:0]    step_q, step_d;

  logic                          out_valid_q, out_valid_d;
  logic                          tx_valid_q, tx_valid_d;
  logic [lne_pkg::CHAR_W-1:0]    tx_byte_q, tx_byte_d;
  logic                          done_q, done_d;
  logic [lne_pkg::LEN_W-1:0]     len_q, len_d;
  logic [lne_pkg::CHAR_W-1:0]    rd_q, rd_d;
  logic                          last_q, last_d;

  logic out_free;
  logic gen_fire;
  logic gen_last;
  logic multi;

  assign out_free = !out_valid_q || out_ready_i;
  assign gen_fire = gen_valid_q && out_free;
  assign multi    = (cmd_q.kind == lne_pkg::KIND_KILL) || (cmd_q.kind == lne_pkg::KIND_ERASE);
  assign gen_last = multi ? (step_q == 2'd2) : 1'b1;
  assign take_o   = !gen_valid_q || (gen_fire && gen_last);

  always_comb begin
    gen_valid_d = gen_valid_q;
    cmd_d       = cmd_q;
    step_d      = step_q;
    if (gen_fire) begin
      if (gen_last) begin
        gen_valid_d = 1'b0;
        step_d      = 2'd0;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
    if (load_i) begin
      gen_valid_d = 1'b1;
      cmd_d       = cmd_i;
      step_d      = 2'd0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    tx_valid_d  = tx_valid_q;
    tx_byte_d   = tx_byte_q;
    done_d      = done_q;
    len_d       = len_q;
    rd_d        = rd_q;
    last_d      = last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (gen_fire) begin
      out_valid_d = 1'b1;
      tx_valid_d  = 1'b1;
      tx_byte_d   = lne_pkg::CH_NUL;
      done_d      = 1'b0;
      len_d       = '0;
      rd_d        = lne_pkg::CH_NUL;
      last_d      = gen_last;
      unique case (cmd_q.kind)
        lne_pkg::KIND_ECHO: begin
          tx_byte_d = cmd_q.ch;
          done_d    = cmd_q.done;
          len_d     = cmd_q.len;
        end
        lne_pkg::KIND_KILL: begin
          case (step_q)
            2'd0:    tx_byte_d = lne_pkg::CH_BSLASH;
            2'd1:    tx_byte_d = lne_pkg::CH_CR;
            default: tx_byte_d = lne_pkg::CH_LF;
          endcase
        end
        lne_pkg::KIND_ERASE: begin
          tx_byte_d = (step_q == 2'd1) ? lne_pkg::CH_SPACE : lne_pkg::CH_BS;
        end
        lne_pkg::KIND_BELL: begin
          tx_byte_d = lne_pkg::CH_BEL;
        end
        lne_pkg::KIND_LINE_END: begin
          tx_valid_d = 1'b0;
          done_d     = 1'b1;
          len_d      = cmd_q.len;
        end
        lne_pkg::KIND_READ: begin
          tx_valid_d = 1'b0;
          rd_d       = cmd_q.rd_zero ? lne_pkg::CH_NUL : rdata_i;
        end
        default: begin
          tx_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_valid_q <= 1'b0;
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      gen_valid_q <= gen_valid_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    tx_valid_q <= tx_valid_d;
    tx_byte_q  <= tx_byte_d;
    done_q     <= done_d;
    len_q      <= len_d;
    rd_q       <= rd_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign tx_valid_o    = tx_valid_q;
  assign tx_byte_o     = tx_byte_q;
  assign line_done_o   = done_q;
  assign line_length_o = len_q;
  assign read_data_o   = rd_q;
  assign last_o        = last_q;

  `LNE_ASSERT(stall_holds_cmd, gen_valid_q && !out_free |=> gen_valid_q && $stable(step_q) && $stable(cmd_q), "Stalled command changed")
  `LNE_ASSERT_ALWAYS(step_in_range, !rst_ni || step_q != 2'd3, "Result step out of range")
  `LNE_ASSERT(step_only_multi, step_q != 2'd0 |-> gen_valid_q && multi, "Step advanced on a single-result command")

endmodule

FILE: hdl/line_editor_with_echo.sv
// Top level of the line editor: decodes each input transfer, keeps the write
// position, drives the line store RAM and feeds the result sequencer.
// Depends on lne_pkg, lne_ram and lne_seq.
//
// Each received byte or read request is taken in one transfer; its results
// leave through an output register, one per cycle unless the output stalls.
// Esc and a backspace with a nonempty line give three results, and the next
// item is taken only as the last of them leaves; every other item but LF
// gives one result, and such items sustain one per cycle. LF is taken and
// gives no result. The sequencer, which emits one result per cycle unless
// the output stalls, sets the rate. The line store sits in a RAM with a
// registered read; a read's data comes from it the cycle after the transfer.
// The entry at size minus one is never written; reads of it, and of indexes
// beyond the store, answer zero. No clearing pass runs after reset.
module line_editor_with_echo #(
  parameter int unsigned LINE_BUFFER_SIZE = lne_pkg::LINE_BUFFER_SIZE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [lne_pkg::CHAR_W-1:0]     rx_byte_i,
  input  logic [lne_pkg::INDEX_W-1:0]    read_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           tx_valid_o,
  output logic [lne_pkg::CHAR_W-1:0]     tx_byte_o,
  output logic                           line_done_o,
  output logic [lne_pkg::LEN_W-1:0]      line_length_o,
  output logic [lne_pkg::CHAR_W-1:0]     read_data_o,
  output logic                           last_o
);

  localparam int unsigned PW = $clog2(LINE_BUFFER_SIZE);
  localparam int unsigned WW = (PW > lne_pkg::INDEX_W) ? PW : lne_pkg::INDEX_W;
  localparam logic [PW-1:0] POS_FULL = PW'(LINE_BUFFER_SIZE - 2);
  localparam logic [WW-1:0] IDX_TERM = WW'(LINE_BUFFER_SIZE - 1);

  logic [PW-1:0] pos_q, pos_d;
  logic          accept;
  logic          load;
  lne_pkg::cmd_t cmd;
  logic          we;
  logic [lne_pkg::CHAR_W-1:0] wdata;
  logic          re;
  logic [lne_pkg::CHAR_W-1:0] rdata;
  logic [PW-1:0] pos_inc;
  logic [WW-1:0] pos_wide;
  logic [WW-1:0] inc_wide;
  logic [WW-1:0] idx_wide;

  assign accept   = in_valid_i && in_ready_o;
  assign pos_inc  = pos_q + PW'(1);
  assign pos_wide = WW'(pos_q);
  assign inc_wide = WW'(pos_inc);
  assign idx_wide = WW'(read_index_i);

  always_comb begin
    pos_d       = pos_q;
    load        = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    wdata       = rx_byte_i;
    cmd.kind    = lne_pkg::KIND_ECHO;
    cmd.ch      = rx_byte_i;
    cmd.done    = 1'b0;
    cmd.len     = '0;
    cmd.rd_zero = idx_wide >= IDX_TERM;
    if (accept) begin
      if (operation_i == lne_pkg::OP_READ) begin
        load     = 1'b1;
        re       = 1'b1;
        cmd.kind = lne_pkg::KIND_READ;
      end else begin
        unique case (rx_byte_i)
          lne_pkg::CH_ESC: begin
            load     = 1'b1;
            cmd.kind = lne_pkg::KIND_KILL;
            pos_d    = '0;
          end
          lne_pkg::CH_LF: begin
            load = 1'b0;
          end
          lne_pkg::CH_BS: begin
            load = 1'b1;
            if (pos_q != '0) begin
              cmd.kind = lne_pkg::KIND_ERASE;
              pos_d    = pos_q - PW'(1);
            end else begin
              cmd.kind = lne_pkg::KIND_BELL;
            end
          end
          lne_pkg::CH_CR: begin
            load     = 1'b1;
            we       = 1'b1;
            wdata    = lne_pkg::CH_NUL;
            cmd.kind = lne_pkg::KIND_LINE_END;
            cmd.len  = pos_wide[lne_pkg::LEN_W-1:0];
            pos_d    = '0;
          end
          default: begin
            load = 1'b1;
            we   = 1'b1;
            if (pos_q == POS_FULL) begin
              cmd.done = 1'b1;
              cmd.len  = inc_wide[lne_pkg::LEN_W-1:0];
              pos_d    = '0;
            end else begin
              pos_d = pos_inc;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  lne_ram #(
    .WIDTH (lne_pkg::CHAR_W),
    .DEPTH (LINE_BUFFER_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (idx_wide[PW-1:0]),
    .rdata_o (rdata)
  );

  lne_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .cmd_i         (cmd),
    .rdata_i       (rdata),
    .take_o        (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tx_valid_o    (tx_valid_o),
    .tx_byte_o     (tx_byte_o),
    .line_done_o   (line_done_o),
    .line_length_o (line_length_o),
    .read_data_o   (read_data_o),
    .last_o        (last_o)
  );

endmodule
